/* src/tif_pkg.sv */
`timescale 1ns / 1ps

package tif_pkg;

    // Telnet command bytes.
    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_SB   = 8'd250;
    localparam logic [7:0] TN_SE   = 8'd240;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACCEPTED_WILL = 2'd0;
    localparam logic [1:0] CFG_SUPPORTED_A   = 2'd1;
    localparam logic [1:0] CFG_SUPPORTED_B   = 2'd2;

    localparam logic [7:0] CFG_ACCEPTED_WILL_RST = 8'd3;
    localparam logic [7:0] CFG_SUPPORTED_A_RST   = 8'd1;
    localparam logic [7:0] CFG_SUPPORTED_B_RST   = 8'd3;

    // Held command verb, stored as the command byte minus WILL.
    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // One result item.
    typedef struct packed {
        logic [7:0] reply_option;
        logic [7:0] reply_verb;
        logic       reply_valid;
        logic [7:0] data_byte;
        logic       data_valid;
    } result_t;

endpackage

/* src/telnet_iac_filter_top.sv */
`timescale 1ns / 1ps

// Channel  | Ports          | Payload
// ---------+----------------+--------------------------------------------
// input    | s_axis_*       | tdata: rx_byte
// result   | m_axis_*       | tdata: data_byte, reply_verb, reply_option
//          |                | tuser: data_valid, reply_valid
// config   | cfg_*          | index 0..2, 8-bit data
//
// One item is accepted per cycle while s_axis_tready is high; its result is
// registered in the output register, or in the skid register while the output is
// stalled. The parser update and result decode sit in one stage between the input
// port and the output register. A skid register behind the output register keeps
// s_axis_tready registered; under a stalled output one more item is taken, then tready drops.
// Synchronous active-low reset returns the parser to normal data and loads
// the option registers with their defaults.

module telnet_iac_filter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // rx_byte [7:0]
    input  logic [tif_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_byte [7:0], reply_verb [15:8], reply_option [23:16]
    output logic [tif_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // data_valid [0], reply_valid [1]
    output logic [tif_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_wdata
);
    import tif_pkg::*;

    typedef enum logic [2:0] {
        ST_NORMAL  = 3'd0,
        ST_GOT_IAC = 3'd1,
        ST_GOT_CMD = 3'd2,
        ST_SB      = 3'd3,
        ST_SB_IAC  = 3'd4
    } parse_state_t;

    parse_state_t state_reg, state_next;
    verb_t        verb_reg, verb_next;

    logic [7:0] accepted_will_reg;
    logic [7:0] supported_a_reg;
    logic [7:0] supported_b_reg;

    result_t out_reg, skid_reg, result_next;
    logic    out_valid_reg, skid_valid_reg;

    logic       s_accept;
    logic       out_free;
    logic [7:0] rx;

    assign rx            = s_axis_tdata;
    assign s_axis_tready = !skid_valid_reg;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.reply_option, out_reg.reply_verb, out_reg.data_byte};
    assign m_axis_tuser  = {out_reg.reply_valid, out_reg.data_valid};

    always_comb begin
        state_next  = state_reg;
        verb_next   = verb_reg;
        result_next = '0;
        unique case (state_reg)
            ST_GOT_IAC: begin
                priority if (rx == TN_IAC) begin
                    // Doubled IAC is an escaped data byte.
                    result_next.data_valid = 1'b1;
                    result_next.data_byte  = rx;
                    state_next             = ST_NORMAL;
                end else if (rx >= TN_WILL && rx <= TN_DONT) begin
                    verb_next  = verb_t'(rx[1:0] - TN_WILL[1:0]);
                    state_next = ST_GOT_CMD;
                end else if (rx == TN_SB) begin
                    state_next = ST_SB;
                end else begin
                    state_next = ST_NORMAL;
                end
            end
            ST_GOT_CMD: begin
                unique case (verb_reg)
                    VERB_WILL: begin
                        result_next.reply_valid  = 1'b1;
                        result_next.reply_verb   =
                            (rx == accepted_will_reg) ? TN_DO : TN_DONT;
                        result_next.reply_option = rx;
                    end
                    VERB_DO: begin
                        if (rx != supported_a_reg && rx != supported_b_reg) begin
                            result_next.reply_valid  = 1'b1;
                            result_next.reply_verb   = TN_WONT;
                            result_next.reply_option = rx;
                        end
                    end
                    VERB_WONT, VERB_DONT: begin
                    end
                    default: begin
                    end
                endcase
                state_next = ST_NORMAL;
            end
            ST_SB: begin
                if (rx == TN_IAC) begin
                    state_next = ST_SB_IAC;
                end
            end
            ST_SB_IAC: begin
                state_next = (rx == TN_SE) ? ST_NORMAL : ST_SB;
            end
            default: begin
                // Normal data; unused codes behave the same way.
                if (rx == TN_IAC) begin
                    state_next = ST_GOT_IAC;
                end else begin
                    state_next             = ST_NORMAL;
                    result_next.data_valid = 1'b1;
                    result_next.data_byte  = rx;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_NORMAL;
            verb_reg          <= VERB_WILL;
            accepted_will_reg <= CFG_ACCEPTED_WILL_RST;
            supported_a_reg   <= CFG_SUPPORTED_A_RST;
            supported_b_reg   <= CFG_SUPPORTED_B_RST;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ACCEPTED_WILL: accepted_will_reg <= cfg_wdata;
                    CFG_SUPPORTED_A:   supported_a_reg   <= cfg_wdata;
                    CFG_SUPPORTED_B:   supported_b_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                state_reg <= state_next;
                verb_reg  <= verb_next;
            end
            if (out_free) begin
                priority if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else if (s_accept) begin
                    out_reg       <= result_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (s_accept) begin
                // Output is stalled: park the item in the skid register.
                skid_reg       <= result_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

/* src/tif_checker.sv */
`timescale 1ns / 1ps

module tif_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic [tif_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [tif_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready
);
    import tif_pkg::*;

    // A stalled result item holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // One input byte never yields both data and a reply.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("data and reply flagged together");

    // A reply carries a legal verb and no data byte.
    a_reply_verb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[15:8] == TN_DO || m_axis_tdata[15:8] == TN_DONT ||
             m_axis_tdata[15:8] == TN_WONT) && m_axis_tdata[7:0] == 8'd0)
        else $error("reply with bad verb or stray data");

    // Reset empties the output side and reopens the input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

endmodule

bind telnet_iac_filter_top tif_checker u_tif_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

/* sim/tb_telnet_iac_filter_top.sv */
`timescale 1ns / 1ps

module tb_telnet_iac_filter_top;
    import tif_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum logic [2:0] {
        PS_NORMAL,
        PS_GOT_IAC,
        PS_GOT_CMD,
        PS_SB,
        PS_SB_IAC
    } parse_t;

    // Tracks the telnet parser and holds the result expected for every byte taken.
    class iac_scoreboard;
        logic [7:0] will_opt;
        logic [7:0] opt_a;
        logic [7:0] opt_b;
        parse_t     state;
        verb_t      held;
        result_t    expected_q[$];
        int         errors;
        int         n_items;
        int         n_results;
        int         n_data;
        int         n_replies;

        function new();
            will_opt  = CFG_ACCEPTED_WILL_RST;
            opt_a     = CFG_SUPPORTED_A_RST;
            opt_b     = CFG_SUPPORTED_B_RST;
            state     = PS_NORMAL;
            held      = VERB_WILL;
            errors    = 0;
            n_items   = 0;
            n_results = 0;
            n_data    = 0;
            n_replies = 0;
        endfunction

        function void set_options(logic [7:0] will_v, logic [7:0] a_v, logic [7:0] b_v);
            will_opt = will_v;
            opt_a    = a_v;
            opt_b    = b_v;
        endfunction

        function void note_rx_byte(logic [7:0] b);
            result_t    r;
            logic [7:0] delta;
            r = '0;
            case (state)
                PS_GOT_IAC: begin
                    if (b == TN_IAC) begin
                        r.data_valid = 1'b1;
                        r.data_byte  = b;
                        state = PS_NORMAL;
                    end else if (b >= TN_WILL && b <= TN_DONT) begin
                        delta = b - TN_WILL;
                        held  = verb_t'(delta[1:0]);
                        state = PS_GOT_CMD;
                    end else if (b == TN_SB) begin
                        state = PS_SB;
                    end else begin
                        state = PS_NORMAL;
                    end
                end
                PS_GOT_CMD: begin
                    if (held == VERB_WILL) begin
                        r.reply_valid  = 1'b1;
                        r.reply_verb   = (b == will_opt) ? TN_DO : TN_DONT;
                        r.reply_option = b;
                    end else if (held == VERB_DO && b != opt_a && b != opt_b) begin
                        r.reply_valid  = 1'b1;
                        r.reply_verb   = TN_WONT;
                        r.reply_option = b;
                    end
                    state = PS_NORMAL;
                end
                PS_SB: begin
                    if (b == TN_IAC) state = PS_SB_IAC;
                end
                PS_SB_IAC: begin
                    state = (b == TN_SE) ? PS_NORMAL : PS_SB;
                end
                default: begin
                    if (b == TN_IAC) begin
                        state = PS_GOT_IAC;
                    end else begin
                        state = PS_NORMAL;
                        r.data_valid = 1'b1;
                        r.data_byte  = b;
                    end
                end
            endcase
            n_items++;
            if (r.data_valid) n_data++;
            if (r.reply_valid) n_replies++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_output(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result arrived with no item outstanding: tdata %h tuser %b",
                       {got.reply_option, got.reply_verb, got.data_byte},
                       {got.reply_valid, got.data_valid});
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_results++;
            compare_field("data_valid", {7'd0, want.data_valid}, {7'd0, got.data_valid});
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("reply_valid", {7'd0, want.reply_valid}, {7'd0, got.reply_valid});
            compare_field("reply_verb", want.reply_verb, got.reply_verb);
            compare_field("reply_option", want.reply_option, got.reply_option);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic [7:0]           cfg_wdata;

    iac_scoreboard sb;
    result_t       seen;
    bit            idle_on = 1'b0;
    bit            hold_out = 1'b0;
    int            stall_cycles = 0;
    int            n_settings = 0;

    telnet_iac_filter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Offers one byte and returns at the edge where it is taken.
    task automatic offer_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_rx_byte(b);
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_set(input logic [7:0] will_v, input logic [7:0] a_v,
                           input logic [7:0] b_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ACCEPTED_WILL;
        cfg_wdata <= will_v;
        @(posedge aclk);
        cfg_index <= CFG_SUPPORTED_A;
        cfg_wdata <= a_v;
        @(posedge aclk);
        cfg_index <= CFG_SUPPORTED_B;
        cfg_wdata <= b_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_options(will_v, a_v, b_v);
        n_settings++;
    endtask

    // Options are drawn half the time from the configured ones so that every reply kind shows up.
    function automatic logic [7:0] pick_option();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0: v = sb.will_opt;
            1: v = sb.opt_a;
            2: v = sb.opt_b;
            3: v = 8'h00;
            4: v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    task automatic send_directed();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'hFE,
                TN_IAC, TN_IAC,
                TN_IAC, TN_WILL, 8'h03,
                TN_IAC, TN_WILL, 8'h00,
                TN_IAC, TN_DO, 8'h01,
                TN_IAC, TN_DO, 8'hFF,
                TN_IAC, TN_WONT, 8'h03,
                TN_IAC, TN_DONT, 8'hFF,
                TN_IAC, TN_SE,
                TN_IAC, TN_SB, TN_IAC, TN_IAC, TN_IAC, TN_SE};
        foreach (seq[i]) offer_byte(seq[i]);
    endtask

    // One piece of telnet traffic: mostly well-formed, with some raw noise.
    task automatic send_traffic();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            b = 8'($urandom_range(0, 254));
            offer_byte(b);
        end else if (pick < 38) begin
            offer_byte(TN_IAC);
            offer_byte(TN_IAC);
        end else if (pick < 70) begin
            offer_byte(TN_IAC);
            b = TN_WILL + 8'($urandom_range(0, 3));
            offer_byte(b);
            offer_byte(pick_option());
        end else if (pick < 78) begin
            // Anything after IAC that is not a verb, SB or IAC is dropped.
            offer_byte(TN_IAC);
            b = 8'($urandom_range(0, 249));
            offer_byte(b);
        end else if (pick < 90) begin
            offer_byte(TN_IAC);
            offer_byte(TN_SB);
            len = $urandom_range(0, 4);
            repeat (len) begin
                b = 8'($urandom_range(0, 254));
                offer_byte(b);
                if ($urandom_range(0, 4) == 0) begin
                    offer_byte(TN_IAC);
                    b = ($urandom_range(0, 1) == 0) ? TN_IAC : 8'($urandom_range(0, 239));
                    offer_byte(b);
                end
            end
            offer_byte(TN_IAC);
            offer_byte(TN_SE);
        end else begin
            b = 8'($urandom_range(0, 255));
            offer_byte(b);
        end
    endtask

    initial begin
        logic [7:0] shared_opt;
        sb = new();
        aresetn       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= CFG_ACCEPTED_WILL;
        cfg_wdata     <= 8'h00;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        send_directed();
        drain();

        cfg_set(8'h00, 8'hFF, 8'h00);
        // The receiver stalls for a long stretch while bytes keep coming.
        hold_out = 1'b1;
        while (sb.n_items < 200) send_traffic();
        drain();

        cfg_set(8'hFF, 8'h00, 8'hFF);
        while (sb.n_items < 300) send_traffic();
        drain();
        while (sb.n_items < 380) send_traffic();
        drain();

        shared_opt = 8'($urandom_range(0, 255));
        cfg_set(8'($urandom_range(0, 255)), shared_opt, shared_opt);
        while (sb.n_items < 520) send_traffic();
        drain();

        cfg_set(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
        idle_on = 1'b0;
        while (sb.n_items < 700) send_traffic();
        drain();

        $display("Checked %0d received bytes against %0d results (%0d data, %0d replies).",
                 sb.n_items, sb.n_results, sb.n_data, sb.n_replies);
        $display("Used %0d option settings plus reset defaults, with one long output stall.",
                 n_settings);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_out) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_out = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.data_valid   = m_axis_tuser[0];
            seen.reply_valid  = m_axis_tuser[1];
            seen.data_byte    = m_axis_tdata[7:0];
            seen.reply_verb   = m_axis_tdata[15:8];
            seen.reply_option = m_axis_tdata[23:16];
            sb.check_output(seen);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
